// ===== src/lcdrx_pkg.sv =====
`default_nettype none

package lcdrx_pkg;

	// Panel geometry
	localparam int MAX_DIM = 320;
	localparam int CFG_W   = 9;
	localparam int DIM_W   = $clog2(MAX_DIM + 1);
	localparam int CMP_W   = (DIM_W > CFG_W) ? DIM_W : CFG_W;
	localparam int CUR_W   = 16;
	localparam int ADDR_W  = 17;
	localparam int PIX_W   = 16;

	// Configuration register indexes
	localparam logic [1:0] REG_PANEL_WIDTH     = 2'd0;
	localparam logic [1:0] REG_PANEL_HEIGHT    = 2'd1;
	localparam logic [1:0] REG_INVERT_POLARITY = 2'd2;

	// Configuration reset values
	localparam logic [CFG_W-1:0] PANEL_WIDTH_RST  = CFG_W'(240);
	localparam logic [CFG_W-1:0] PANEL_HEIGHT_RST = CFG_W'(320);

	// Link functions
	typedef enum logic [1:0] {
		FUNC_CMD         = 2'd0,
		FUNC_DATA        = 2'd1,
		FUNC_RST_ASSERT  = 2'd2,
		FUNC_RST_RELEASE = 2'd3
	} func_t;

	// Internal pixel formats
	typedef enum logic [1:0] {
		FMT_565 = 2'd0,
		FMT_444 = 2'd1,
		FMT_666 = 2'd2
	} fmt_t;

	// Command codes
	localparam logic [7:0] CMD_NOP        = 8'h00;
	localparam logic [7:0] CMD_SW_RESET   = 8'h01;
	localparam logic [7:0] CMD_SLEEP_OUT  = 8'h11;
	localparam logic [7:0] CMD_INV_OFF    = 8'h20;
	localparam logic [7:0] CMD_INV_ON     = 8'h21;
	localparam logic [7:0] CMD_DISP_ON    = 8'h29;
	localparam logic [7:0] CMD_COL_WIN    = 8'h2A;
	localparam logic [7:0] CMD_ROW_WIN    = 8'h2B;
	localparam logic [7:0] CMD_MEM_WRITE  = 8'h2C;
	localparam logic [7:0] CMD_ACCESS_CTL = 8'h36;
	localparam logic [7:0] CMD_PIX_FORMAT = 8'h3A;

	// Pixel format codes of the format command
	localparam logic [2:0] COLMOD_444 = 3'd3;
	localparam logic [2:0] COLMOD_565 = 3'd5;
	localparam logic [2:0] COLMOD_666 = 3'd6;

	// Memory access control bits
	localparam int MADCTL_BGR = 3;
	localparam int MADCTL_MV  = 5;
	localparam int MADCTL_MX  = 6;
	localparam int MADCTL_MY  = 7;

	// Result of one processing step, before the address multiply
	typedef struct packed {
		logic             has;
		logic [DIM_W-1:0] x;
		logic [DIM_W-1:0] y;
		logic [DIM_W-1:0] w;
		logic [PIX_W-1:0] value;
		logic             last;
		logic             clr;
		logic             sleeping;
		logic             display_on;
		logic             inverted;
	} res_t;

	// Clamp a panel dimension register to 1..MAX_DIM
	function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
		logic [CMP_W-1:0] vw;
		vw = CMP_W'(v);
		if (v == '0) begin
			return DIM_W'(1);
		end else if (vw > CMP_W'(MAX_DIM)) begin
			return DIM_W'(MAX_DIM);
		end else begin
			return DIM_W'(vw);
		end
	endfunction

	localparam logic [CUR_W-1:0] COL_LAST_RST =
		CUR_W'(eff_dim(PANEL_WIDTH_RST) - DIM_W'(1));
	localparam logic [CUR_W-1:0] ROW_LAST_RST =
		CUR_W'(eff_dim(PANEL_HEIGHT_RST) - DIM_W'(1));

endpackage

`default_nettype wire

// ===== src/lcdrx_in_reg.sv =====
`default_nettype none

module lcdrx_in_reg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] func,
	input  wire logic [7:0] bus_byte,
	input  wire logic       s1_taken,
	output logic            valid_s1,
	output logic [1:0]      func_s1,
	output logic [7:0]      byte_s1
);
	import lcdrx_pkg::*;

	logic accept;

	// Hold the item until the core takes it
	assign in_stall = valid_s1 && !s1_taken;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !s1_taken);
		end
	end

	// Capture the transaction payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			byte_s1 <= bus_byte;
		end
	end

endmodule

`default_nettype wire

// ===== src/lcdrx_core.sv =====
`default_nettype none

module lcdrx_core (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [lcdrx_pkg::DIM_W-1:0] eff_w,
	input  wire logic [lcdrx_pkg::DIM_W-1:0] eff_h,
	input  wire logic                    polarity,
	input  wire logic                    valid_s1,
	input  wire logic [1:0]              func_s1,
	input  wire logic [7:0]              byte_s1,
	output logic                         s1_taken,
	input  wire logic                    ready_s3,
	output logic                         valid_s2,
	output lcdrx_pkg::res_t              res_s2
);
	import lcdrx_pkg::*;

	// Controller state
	logic             sleep_q, sleep_d;
	logic             enable_q, enable_d;
	logic             invert_q, invert_d;
	fmt_t             fmt_q, fmt_d;
	logic [7:0]       acc_q, acc_d;
	logic [7:0]       act_q, act_d;
	logic [2:0]       pc_q, pc_d;
	logic [CUR_W-1:0] col_first_q, col_first_d;
	logic [CUR_W-1:0] col_last_q, col_last_d;
	logic [CUR_W-1:0] row_first_q, row_first_d;
	logic [CUR_W-1:0] row_last_q, row_last_d;
	logic [CUR_W-1:0] cur_col_q, cur_col_d;
	logic [CUR_W-1:0] cur_row_q, cur_row_d;
	logic [7:0]       held0_q, held0_d;
	logic [7:0]       held1_q, held1_d;
	logic [1:0]       hc_q, hc_d;
	logic             rst_held_q, rst_held_d;
	logic             phase_q, phase_d;

	logic             work;
	logic             emit;
	logic             last_r;
	logic             clr;
	logic             sw_rst;
	logic             inc_pc;
	logic [PIX_W-1:0] pix;
	logic [PIX_W-1:0] pix_p1, pix_p2, pix_666, pix_565;
	logic [PIX_W-1:0] pix_sw;
	logic [CUR_W-1:0] x_sel, y_sel;
	logic             in_range;
	logic [DIM_W-1:0] x_fb, y_fb;
	logic [CUR_W-1:0] next_col, next_row;
	func_t            fn;
	res_t             res;

	function automatic logic [4:0] exp45(input logic [3:0] v);
		return {v, v[3]};
	endfunction

	function automatic logic [5:0] exp46(input logic [3:0] v);
		return {v, v[3:2]};
	endfunction

	assign fn = func_t'(func_s1);

	// Advance when the next stage has room
	assign work     = valid_s1 && (!valid_s2 || ready_s3);
	assign s1_taken = work && !phase_d;

	// Assemble candidate pixels from held bytes and the current byte
	assign pix_p1  = {exp45(held0_q[7:4]), exp46(held0_q[3:0]), exp45(held1_q[7:4])};
	assign pix_p2  = {exp45(held1_q[3:0]), exp46(byte_s1[7:4]), exp45(byte_s1[3:0])};
	assign pix_666 = {held0_q[7:3], held1_q[7:2], byte_s1[7:3]};
	assign pix_565 = {held0_q, byte_s1};

	// Decode the transaction and compute next state
	always_comb begin
		sleep_d     = sleep_q;
		enable_d    = enable_q;
		invert_d    = invert_q;
		fmt_d       = fmt_q;
		acc_d       = acc_q;
		act_d       = act_q;
		pc_d        = pc_q;
		col_first_d = col_first_q;
		col_last_d  = col_last_q;
		row_first_d = row_first_q;
		row_last_d  = row_last_q;
		cur_col_d   = cur_col_q;
		cur_row_d   = cur_row_q;
		held0_d     = held0_q;
		held1_d     = held1_q;
		hc_d        = hc_q;
		rst_held_d  = rst_held_q;
		phase_d     = 1'b0;
		emit        = 1'b0;
		last_r      = 1'b1;
		clr         = 1'b0;
		sw_rst      = 1'b0;
		inc_pc      = 1'b0;
		pix         = pix_565;

		if (phase_q) begin
			// Second pixel of a 444 pair
			emit = 1'b1;
			pix  = pix_p2;
		end else begin
			case (fn)
				FUNC_RST_ASSERT: rst_held_d = 1'b1;
				FUNC_RST_RELEASE: begin
					rst_held_d = 1'b0;
					sw_rst     = 1'b1;
					clr        = 1'b1;
				end
				FUNC_CMD: if (!rst_held_q) begin
					act_d = byte_s1;
					pc_d  = 3'd0;
					hc_d  = 2'd0;
					case (byte_s1)
						CMD_SW_RESET: begin
							sw_rst = 1'b1;
							clr    = 1'b1;
						end
						CMD_SLEEP_OUT: sleep_d  = 1'b0;
						CMD_INV_OFF:   invert_d = polarity;
						CMD_INV_ON:    invert_d = !polarity;
						CMD_DISP_ON:   enable_d = 1'b1;
						CMD_MEM_WRITE: begin
							cur_col_d = col_first_q;
							cur_row_d = row_first_q;
						end
						default: ;
					endcase
				end
				FUNC_DATA: if (!rst_held_q) begin
					if (act_q == CMD_MEM_WRITE) begin
						case (fmt_q)
							FMT_444, FMT_666: begin
								if (hc_q < 2'd2) begin
									if (hc_q[0]) held1_d = byte_s1;
									else held0_d = byte_s1;
									hc_d = 2'(hc_q + 2'd1);
								end else begin
									hc_d = 2'd0;
									emit = 1'b1;
									if (fmt_q == FMT_444) begin
										pix     = pix_p1;
										last_r  = 1'b0;
										phase_d = 1'b1;
									end else begin
										pix = pix_666;
									end
								end
							end
							default: begin
								if (hc_q == 2'd0) begin
									held0_d = byte_s1;
									hc_d    = 2'd1;
								end else begin
									hc_d = 2'd0;
									emit = 1'b1;
								end
							end
						endcase
					end else begin
						case (act_q)
							CMD_ACCESS_CTL: begin
								inc_pc = 1'b1;
								if (pc_q == 3'd0) acc_d = byte_s1;
							end
							CMD_PIX_FORMAT: begin
								inc_pc = 1'b1;
								if (pc_q == 3'd0) begin
									hc_d = 2'd0;
									case (byte_s1[2:0])
										COLMOD_444: fmt_d = FMT_444;
										COLMOD_565: fmt_d = FMT_565;
										COLMOD_666: fmt_d = FMT_666;
										default: ;
									endcase
								end
							end
							CMD_COL_WIN: begin
								inc_pc = 1'b1;
								case (pc_q)
									3'd0, 3'd2: held0_d = byte_s1;
									3'd1: col_first_d = {held0_q, byte_s1};
									3'd3: col_last_d  = {held0_q, byte_s1};
									default: ;
								endcase
							end
							CMD_ROW_WIN: begin
								inc_pc = 1'b1;
								case (pc_q)
									3'd0, 3'd2: held0_d = byte_s1;
									3'd1: row_first_d = {held0_q, byte_s1};
									3'd3: row_last_d  = {held0_q, byte_s1};
									default: ;
								endcase
							end
							default: ;
						endcase
						if (inc_pc && pc_q < 3'd4) pc_d = 3'(pc_q + 3'd1);
					end
				end
				default: ;
			endcase
		end

		// Step the write cursor through the window
		next_col = CUR_W'(cur_col_q + CUR_W'(1));
		next_row = CUR_W'(cur_row_q + CUR_W'(1));
		if (emit) begin
			if (next_col > col_last_q) begin
				cur_col_d = col_first_q;
				cur_row_d = (next_row > row_last_q) ? row_first_q : next_row;
			end else begin
				cur_col_d = next_col;
			end
		end

		// Return to the power-on state
		if (sw_rst) begin
			sleep_d     = 1'b1;
			enable_d    = 1'b0;
			invert_d    = 1'b0;
			fmt_d       = FMT_565;
			acc_d       = 8'h00;
			act_d       = CMD_NOP;
			pc_d        = 3'd0;
			col_first_d = '0;
			col_last_d  = CUR_W'(eff_w - DIM_W'(1));
			row_first_d = '0;
			row_last_d  = CUR_W'(eff_h - DIM_W'(1));
			cur_col_d   = '0;
			cur_row_d   = '0;
			hc_d        = 2'd0;
		end
	end

	// Map the cursor onto the panel
	always_comb begin
		pix_sw = acc_q[MADCTL_BGR] ? {pix[4:0], pix[10:5], pix[15:11]} : pix;
		x_sel  = acc_q[MADCTL_MV] ? cur_row_q : cur_col_q;
		y_sel  = acc_q[MADCTL_MV] ? cur_col_q : cur_row_q;
		in_range = (x_sel < CUR_W'(eff_w)) && (y_sel < CUR_W'(eff_h));
		x_fb = acc_q[MADCTL_MX] ? DIM_W'(eff_w - DIM_W'(1) - x_sel[DIM_W-1:0])
		                        : x_sel[DIM_W-1:0];
		y_fb = acc_q[MADCTL_MY] ? DIM_W'(eff_h - DIM_W'(1) - y_sel[DIM_W-1:0])
		                        : y_sel[DIM_W-1:0];

		res            = '0;
		res.has        = emit && in_range;
		res.x          = res.has ? x_fb : '0;
		res.y          = res.has ? y_fb : '0;
		res.w          = eff_w;
		res.value      = res.has ? pix_sw : '0;
		res.last       = last_r;
		res.clr        = clr;
		res.sleeping   = sleep_d;
		res.display_on = enable_d;
		res.inverted   = invert_d;
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sleep_q     <= 1'b1;
			enable_q    <= 1'b0;
			invert_q    <= 1'b0;
			fmt_q       <= FMT_565;
			acc_q       <= 8'h00;
			act_q       <= CMD_NOP;
			pc_q        <= 3'd0;
			col_first_q <= '0;
			col_last_q  <= COL_LAST_RST;
			row_first_q <= '0;
			row_last_q  <= ROW_LAST_RST;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			hc_q        <= 2'd0;
			rst_held_q  <= 1'b0;
			phase_q     <= 1'b0;
			valid_s2    <= 1'b0;
		end else begin
			if (work) begin
				sleep_q     <= sleep_d;
				enable_q    <= enable_d;
				invert_q    <= invert_d;
				fmt_q       <= fmt_d;
				acc_q       <= acc_d;
				act_q       <= act_d;
				pc_q        <= pc_d;
				col_first_q <= col_first_d;
				col_last_q  <= col_last_d;
				row_first_q <= row_first_d;
				row_last_q  <= row_last_d;
				cur_col_q   <= cur_col_d;
				cur_row_q   <= cur_row_d;
				hc_q        <= hc_d;
				rst_held_q  <= rst_held_d;
				phase_q     <= phase_d;
			end
			valid_s2 <= work || (valid_s2 && !ready_s3);
		end
	end

	// Held bytes and the stage result
	always_ff @(posedge clk) begin
		if (work) begin
			held0_q <= held0_d;
			held1_q <= held1_d;
			res_s2  <= res;
		end
	end

`ifndef SYNTHESIS
	a_phase_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> valid_s1)
		else $error("second pixel pending without a held item");

	a_phase_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> fmt_q == FMT_444)
		else $error("second pixel pending outside 444 format");

	a_first_of_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.last) |-> phase_q)
		else $error("non-final result without a pending second pixel");

	a_pixel_no_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.has) |-> !res_s2.clr)
		else $error("pixel write carries a frame clear");
`endif

endmodule

`default_nettype wire

// ===== src/lcdrx_out.sv =====
`default_nettype none

module lcdrx_out (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         valid_s2,
	input  wire lcdrx_pkg::res_t              res_s2,
	output logic                              ready_s3,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              has_pixel,
	output logic [lcdrx_pkg::ADDR_W-1:0]      pixel_address,
	output logic [lcdrx_pkg::PIX_W-1:0]       pixel_value,
	output logic                              last,
	output logic                              clear_frame,
	output logic                              sleeping,
	output logic                              display_on,
	output logic                              inverted
);
	import lcdrx_pkg::*;

	logic [2*DIM_W-1:0] row_base;
	logic [2*DIM_W:0]   addr_sum;

	// Row times width plus column
	assign row_base = res_s2.y * res_s2.w;
	assign addr_sum = (2*DIM_W+1)'(row_base) + (2*DIM_W+1)'(res_s2.x);

	assign ready_s3 = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ready_s3) begin
			out_valid <= valid_s2;
		end
	end

	// Load the result register when a result waits and the register is empty or the consumer is not stalling
	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			has_pixel     <= res_s2.has;
			pixel_address <= ADDR_W'(addr_sum);
			pixel_value   <= res_s2.value;
			last          <= res_s2.last;
			clear_frame   <= res_s2.clr;
			sleeping      <= res_s2.sleeping;
			display_on    <= res_s2.display_on;
			inverted      <= res_s2.inverted;
		end
	end

endmodule

`default_nettype wire

// ===== src/lcd_command_and_pixel_write_receiver.sv =====
// Command and pixel write receiver for a serial display link.
// Input channel (in_valid/in_stall): one transaction per link event, func
// selects command byte, data byte, reset assert or reset release.
// Output channel (out_valid/out_stall): one result per input, two for a byte
// that completes a 444 pixel pair. A result carries an optional framebuffer
// write (address, 565 value), a last marker, a frame clear request and the
// current sleep, display-on and inversion flags.
// Configuration port (cfg_write/cfg_index/cfg_data): panel width, height and
// inversion polarity; write only while no transaction is in flight.
// Pipeline: an accepted input is decoded into the stage register, then the
// address multiply loads the output register.
// Throughput: one input per cycle while the output does not stall; a byte
// completing a 444 pair holds the decode stage until both pixels have passed,
// one after the other, since each pixel steps the write cursor.
// Reset: all flags and windows return to their power-on values, config
// registers to 240 x 320 with normal polarity; no pipeline stage holds data.
// A stalled output holds its result; the stages behind it fill, then
// in_stall rises until out_stall drops.

`default_nettype none

module lcd_command_and_pixel_write_receiver (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write,
	input  wire logic [1:0]                         cfg_index,
	input  wire logic [lcdrx_pkg::CFG_W-1:0]        cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [1:0]                         func,
	input  wire logic [7:0]                         bus_byte,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    has_pixel,
	output logic [lcdrx_pkg::ADDR_W-1:0]            pixel_address,
	output logic [lcdrx_pkg::PIX_W-1:0]             pixel_value,
	output logic                                    last,
	output logic                                    clear_frame,
	output logic                                    sleeping,
	output logic                                    display_on,
	output logic                                    inverted
);
	import lcdrx_pkg::*;

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic             polarity_q;
	logic [DIM_W-1:0] eff_w;
	logic [DIM_W-1:0] eff_h;

	logic       s1_taken;
	logic       valid_s1;
	logic [1:0] func_s1;
	logic [7:0] byte_s1;
	logic       ready_s3;
	logic       valid_s2;
	res_t       res_s2;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= PANEL_WIDTH_RST;
			height_q   <= PANEL_HEIGHT_RST;
			polarity_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PANEL_WIDTH:     width_q    <= cfg_data;
				REG_PANEL_HEIGHT:    height_q   <= cfg_data;
				REG_INVERT_POLARITY: polarity_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamp panel size
	assign eff_w = eff_dim(width_q);
	assign eff_h = eff_dim(height_q);

	lcdrx_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.bus_byte (bus_byte),
		.s1_taken (s1_taken),
		.valid_s1 (valid_s1),
		.func_s1  (func_s1),
		.byte_s1  (byte_s1)
	);

	lcdrx_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.eff_w    (eff_w),
		.eff_h    (eff_h),
		.polarity (polarity_q),
		.valid_s1 (valid_s1),
		.func_s1  (func_s1),
		.byte_s1  (byte_s1),
		.s1_taken (s1_taken),
		.ready_s3 (ready_s3),
		.valid_s2 (valid_s2),
		.res_s2   (res_s2)
	);

	lcdrx_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s2      (valid_s2),
		.res_s2        (res_s2),
		.ready_s3      (ready_s3),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.has_pixel     (has_pixel),
		.pixel_address (pixel_address),
		.pixel_value   (pixel_value),
		.last          (last),
		.clear_frame   (clear_frame),
		.sleeping      (sleeping),
		.display_on    (display_on),
		.inverted      (inverted)
	);

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lcdrx_pkg::*;

	localparam int          CYCLE_LIMIT   = 400000;
	localparam int          NUM_PHASES    = 8;
	localparam int          PHASE_ITEMS   = 175;
	localparam int          REPORT_LIMIT  = 60;
	localparam int          DRAIN_CYCLES  = 8;
	localparam int          NUM_DIRECTED  = 29;

	// Geometry and polarity of the fixed phases; later phases pick at random
	localparam int unsigned PHASE_W   [6] = '{240, 1, 320, 0, 511, 320};
	localparam int unsigned PHASE_H   [6] = '{320, 1, 320, 0, 511, 1};
	localparam int unsigned PHASE_POL [6] = '{0, 1, 0, 1, 0, 1};

	// Opening sequence: every command but no-op and the window ones, every format, reset hold and odd cases
	localparam logic [9:0] DIRECTED_ITEMS [NUM_DIRECTED] = '{
		{FUNC_RST_RELEASE, 8'h00},
		{FUNC_CMD, CMD_SLEEP_OUT}, {FUNC_DATA, 8'h00},
		{FUNC_CMD, CMD_DISP_ON}, {FUNC_CMD, CMD_INV_ON},
		{FUNC_CMD, CMD_MEM_WRITE}, {FUNC_DATA, 8'hFF}, {FUNC_DATA, 8'hFF},
		{FUNC_CMD, CMD_PIX_FORMAT}, {FUNC_DATA, 8'h03},
		{FUNC_CMD, CMD_MEM_WRITE}, {FUNC_DATA, 8'hF0}, {FUNC_DATA, 8'h0F}, {FUNC_DATA, 8'hA5},
		{FUNC_CMD, CMD_ACCESS_CTL}, {FUNC_DATA, 8'hE8},
		{FUNC_CMD, CMD_PIX_FORMAT}, {FUNC_DATA, 8'h06},
		{FUNC_CMD, CMD_MEM_WRITE}, {FUNC_DATA, 8'h00}, {FUNC_DATA, 8'hFF}, {FUNC_DATA, 8'h80},
		{FUNC_RST_ASSERT, 8'hFF}, {FUNC_DATA, 8'h55}, {FUNC_CMD, CMD_SW_RESET},
		{FUNC_RST_RELEASE, 8'h00},
		{FUNC_CMD, CMD_INV_OFF}, {FUNC_CMD, 8'hFF},
		{FUNC_CMD, CMD_SW_RESET}
	};

	typedef enum {
		STALL_OFF,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	typedef struct packed {
		logic              has;
		logic [ADDR_W-1:0] address;
		logic [PIX_W-1:0]  value;
		logic              is_last;
		logic              clear;
		logic              asleep;
		logic              disp_on;
		logic              inv;
	} lcd_result_t;

	// Tracks controller state and queues the framebuffer writes each byte causes
	class frame_write_scoreboard;
		int unsigned cfg_w, cfg_h;
		bit          cfg_swap_inv;
		bit          asleep, shown_on, colors_inv, in_reset;
		fmt_t        fmt;
		logic [7:0]  madctl, cur_cmd;
		int unsigned nparam, nheld;
		logic [15:0] col_lo, col_hi, row_lo, row_hi, cur_col, cur_row;
		logic [7:0]  hold [2];
		lcd_result_t pending [$];
		int          errors;
		int          reports;

		function new();
			cfg_w = 240;
			cfg_h = 320;
			cfg_swap_inv = 1'b0;
			hold[0] = '0;
			hold[1] = '0;
			in_reset = 1'b0;
			errors = 0;
			reports = 0;
			restart();
		endfunction

		function int unsigned clamp_dim(int unsigned v);
			if (v < 1) return 1;
			if (v > MAX_DIM) return MAX_DIM;
			return v;
		endfunction

		// Return to power-on state; held bytes and the reset line stay as they are
		function void restart();
			asleep = 1'b1;
			shown_on = 1'b0;
			colors_inv = 1'b0;
			fmt = FMT_565;
			madctl = '0;
			cur_cmd = CMD_NOP;
			nparam = 0;
			col_lo = '0;
			col_hi = 16'(clamp_dim(cfg_w) - 1);
			row_lo = '0;
			row_hi = 16'(clamp_dim(cfg_h) - 1);
			cur_col = '0;
			cur_row = '0;
			nheld = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
			case (idx)
				REG_PANEL_WIDTH: cfg_w = value;
				REG_PANEL_HEIGHT: cfg_h = value;
				REG_INVERT_POLARITY: cfg_swap_inv = value[0];
				default: ;
			endcase
		endfunction

		function lcd_result_t make_result(bit has, logic [ADDR_W-1:0] address,
				logic [PIX_W-1:0] value, bit is_last, bit clear);
			lcd_result_t r;
			r.has = has;
			r.address = address;
			r.value = value;
			r.is_last = is_last;
			r.clear = clear;
			r.asleep = asleep;
			r.disp_on = shown_on;
			r.inv = colors_inv;
			return r;
		endfunction

		function logic [15:0] pack444(logic [3:0] r, logic [3:0] g, logic [3:0] b);
			return {r, r[3], g, g[3:2], b, b[3]};
		endfunction

		// Queue one pixel at the cursor, then step the cursor through the window
		function void emit_pixel(logic [15:0] px, bit is_last);
			int unsigned w, h, x, y;
			logic [15:0] v;
			w = clamp_dim(cfg_w);
			h = clamp_dim(cfg_h);
			x = madctl[MADCTL_MV] ? cur_row : cur_col;
			y = madctl[MADCTL_MV] ? cur_col : cur_row;
			v = madctl[MADCTL_BGR] ? {px[4:0], px[10:5], px[15:11]} : px;
			if (x < w && y < h) begin
				if (madctl[MADCTL_MX]) x = w - 1 - x;
				if (madctl[MADCTL_MY]) y = h - 1 - y;
				pending.push_back(make_result(1'b1, ADDR_W'(y * w + x), v, is_last, 1'b0));
			end else begin
				pending.push_back(make_result(1'b0, '0, '0, is_last, 1'b0));
			end
			cur_col = cur_col + 16'd1;
			if (cur_col > col_hi) begin
				cur_col = col_lo;
				cur_row = cur_row + 16'd1;
				if (cur_row > row_hi) cur_row = row_lo;
			end
		endfunction

		// Column or row address parameters: high byte then low byte, first then last
		function void window_byte(bit is_row, logic [7:0] b);
			logic [15:0] word;
			word = {hold[0], b};
			case (nparam)
				0, 2: hold[0] = b;
				1: if (is_row) row_lo = word; else col_lo = word;
				3: if (is_row) row_hi = word; else col_hi = word;
				default: ;
			endcase
		endfunction

		function void note_transaction(logic [1:0] f, logic [7:0] b);
			bit clear;
			bit known;
			clear = 1'b0;
			known = 1'b1;
			case (f)
				FUNC_RST_ASSERT: in_reset = 1'b1;
				FUNC_RST_RELEASE: begin
					in_reset = 1'b0;
					restart();
					clear = 1'b1;
				end
				FUNC_CMD: if (!in_reset) begin
					cur_cmd = b;
					nparam = 0;
					nheld = 0;
					case (b)
						CMD_SW_RESET: begin
							restart();
							clear = 1'b1;
						end
						CMD_SLEEP_OUT: asleep = 1'b0;
						CMD_INV_OFF: colors_inv = cfg_swap_inv;
						CMD_INV_ON: colors_inv = !cfg_swap_inv;
						CMD_DISP_ON: shown_on = 1'b1;
						CMD_MEM_WRITE: begin
							cur_col = col_lo;
							cur_row = row_lo;
						end
						default: ;
					endcase
				end
				default: if (!in_reset) begin
					if (cur_cmd == CMD_MEM_WRITE) begin
						// Gather pixel bytes; a completed pixel replaces the plain result
						if (fmt == FMT_565) begin
							if (nheld == 0) begin
								hold[0] = b;
								nheld = 1;
							end else begin
								nheld = 0;
								emit_pixel({hold[0], b}, 1'b1);
								return;
							end
						end else if (nheld < 2) begin
							hold[nheld] = b;
							nheld++;
						end else begin
							nheld = 0;
							if (fmt == FMT_444) begin
								emit_pixel(pack444(hold[0][7:4], hold[0][3:0], hold[1][7:4]), 1'b0);
								emit_pixel(pack444(hold[1][3:0], b[7:4], b[3:0]), 1'b1);
							end else begin
								emit_pixel({hold[0][7:3], hold[1][7:2], b[7:3]}, 1'b1);
							end
							return;
						end
					end else begin
						case (cur_cmd)
							CMD_ACCESS_CTL: if (nparam == 0) madctl = b;
							CMD_PIX_FORMAT: if (nparam == 0) begin
								case (b[2:0])
									COLMOD_444: fmt = FMT_444;
									COLMOD_565: fmt = FMT_565;
									COLMOD_666: fmt = FMT_666;
									default: ;
								endcase
								nheld = 0;
							end
							CMD_COL_WIN: window_byte(1'b0, b);
							CMD_ROW_WIN: window_byte(1'b1, b);
							default: known = 1'b0;
						endcase
						if (known && nparam < 4) nparam++;
					end
				end
			endcase
			pending.push_back(make_result(1'b0, '0, '0, 1'b1, clear));
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				if (reports < REPORT_LIMIT) begin
					reports++;
					$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
				end
			end
		endfunction

		function void check_result(lcd_result_t got);
			lcd_result_t want;
			if (pending.size() == 0) begin
				errors++;
				if (reports < REPORT_LIMIT) begin
					reports++;
					$display("%0t: unexpected result: expected none, got has_pixel %0b address %0h value %0h",
						$time, got.has, got.address, got.value);
				end
				return;
			end
			want = pending.pop_front();
			compare_field("has_pixel", want.has, got.has);
			compare_field("pixel_address", want.address, got.address);
			compare_field("pixel_value", want.value, got.value);
			compare_field("last", want.is_last, got.is_last);
			compare_field("clear_frame", want.clear, got.clear);
			compare_field("sleeping", want.asleep, got.asleep);
			compare_field("display_on", want.disp_on, got.disp_on);
			compare_field("inverted", want.inv, got.inv);
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_write;
	logic [1:0]        cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        func;
	logic [7:0]        bus_byte;
	logic              out_valid;
	logic              out_stall;
	logic              has_pixel;
	logic [ADDR_W-1:0] pixel_address;
	logic [PIX_W-1:0]  pixel_value;
	logic              last;
	logic              clear_frame;
	logic              sleeping;
	logic              display_on;
	logic              inverted;

	frame_write_scoreboard board;
	int                    burst_left;
	int                    items_sent;
	int                    cycle_count;

	lcd_command_and_pixel_write_receiver u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.bus_byte      (bus_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.has_pixel     (has_pixel),
		.pixel_address (pixel_address),
		.pixel_value   (pixel_value),
		.last          (last),
		.clear_frame   (clear_frame),
		.sleeping      (sleeping),
		.display_on    (display_on),
		.inverted      (inverted)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Drive one link transaction, hold it until accepted, then pace the burst
	task automatic send_link(input logic [1:0] f, input logic [7:0] b);
		int gap;
		in_valid = 1'b1;
		func = f;
		bus_byte = b;
		do @(posedge clk); while (in_stall);
		if (f == FUNC_RST_ASSERT || f == FUNC_RST_RELEASE || !board.in_reset) items_sent++;
		board.note_transaction(f, b);
		@(negedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
		end
	endtask

	// Drop valid, drain every pending result, then let the pipeline settle
	task automatic wait_idle();
		in_valid = 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int unsigned value);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = CFG_W'(value);
		@(negedge clk);
		cfg_write = 1'b0;
		board.set_reg(idx, CFG_W'(value));
	endtask

	// Column or row window command with mostly in-panel bounds
	task automatic send_window(input logic [7:0] cmd);
		int unsigned dim, nbytes, k;
		logic [15:0] lo, hi;
		logic [7:0]  params [4];
		dim = board.clamp_dim(board.cfg_w);
		if (board.clamp_dim(board.cfg_h) > dim) dim = board.clamp_dim(board.cfg_h);
		if ($urandom_range(0, 7) == 0) begin
			lo = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
			hi = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
		end else begin
			lo = 16'($urandom_range(0, dim + 3));
			hi = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, dim + 3))
				: lo + 16'($urandom_range(0, 6));
		end
		params = '{lo[15:8], lo[7:0], hi[15:8], hi[7:0]};
		case ($urandom_range(0, 9))
			0: nbytes = $urandom_range(0, 3);
			1: nbytes = $urandom_range(5, 7);
			default: nbytes = 4;
		endcase
		send_link(FUNC_CMD, cmd);
		for (k = 0; k < nbytes; k++)
			send_link(FUNC_DATA, (k < 4) ? params[k] : 8'($urandom));
	endtask

	task automatic send_pixels();
		int n, k;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(37, 120) : $urandom_range(1, 36);
		send_link(FUNC_CMD, CMD_MEM_WRITE);
		for (k = 0; k < n; k++)
			send_link(FUNC_DATA, 8'($urandom));
	endtask

	task automatic send_command();
		logic [7:0] code;
		case ($urandom_range(0, 6))
			0: code = CMD_SLEEP_OUT;
			1: code = CMD_INV_OFF;
			2: code = CMD_INV_ON;
			3: code = CMD_DISP_ON;
			4: code = CMD_SW_RESET;
			5: code = CMD_NOP;
			default: code = 8'($urandom);
		endcase
		send_link(FUNC_CMD, code);
		if ($urandom_range(0, 3) == 0) send_link(FUNC_DATA, 8'($urandom));
	endtask

	// Receiver stalls: alternate between quiet, random and periodic stretches
	initial begin : receiver_stalls
		stall_mode_t mode;
		int          span, period, duty, k;
		out_stall = 1'b0;
		forever begin
			mode = stall_mode_t'($urandom_range(0, 3));
			span = $urandom_range(20, 200);
			period = $urandom_range(2, 9);
			duty = $urandom_range(1, period - 1);
			for (k = 0; k < span; k++) begin
				@(negedge clk);
				case (mode)
					STALL_OFF: out_stall = 1'b0;
					STALL_LIGHT: out_stall = ($urandom_range(0, 99) < 30);
					STALL_HEAVY: out_stall = ($urandom_range(0, 99) < 75);
					default: out_stall = ((k % period) < duty);
				endcase
			end
		end
	end

	// Check each accepted result against the oldest queued write
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(lcd_result_t'({has_pixel, pixel_address, pixel_value, last,
				clear_frame, sleeping, display_on, inverted}));
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		int          i, k, n, pick, phase, phase_end;
		int unsigned w, h, pol;
		logic [2:0]  code;
		board = new();
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		func = '0;
		bus_byte = '0;
		burst_left = 1;
		items_sent = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (i = 0; i < NUM_DIRECTED; i++)
			send_link(DIRECTED_ITEMS[i][9:8], DIRECTED_ITEMS[i][7:0]);

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			// Reconfigure only with the block drained
			wait_idle();
			if (phase < 6) begin
				w = PHASE_W[phase];
				h = PHASE_H[phase];
				pol = PHASE_POL[phase];
			end else begin
				w = $urandom_range(0, 511);
				h = $urandom_range(0, 511);
				pol = $urandom_range(0, 1);
			end
			write_reg(REG_PANEL_WIDTH, w);
			write_reg(REG_PANEL_HEIGHT, h);
			write_reg(REG_INVERT_POLARITY, pol);
			send_link(FUNC_RST_RELEASE, 8'($urandom));

			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					send_pixels();
				end else if (pick < 50) begin
					send_window(CMD_COL_WIN);
				end else if (pick < 60) begin
					send_window(CMD_ROW_WIN);
				end else if (pick < 70) begin
					// Pixel format, mostly a valid code
					case ($urandom_range(0, 2))
						0: code = COLMOD_444;
						1: code = COLMOD_565;
						default: code = COLMOD_666;
					endcase
					send_link(FUNC_CMD, CMD_PIX_FORMAT);
					send_link(FUNC_DATA, ($urandom_range(0, 9) == 0) ? 8'($urandom)
						: {5'($urandom), code});
				end else if (pick < 78) begin
					send_link(FUNC_CMD, CMD_ACCESS_CTL);
					send_link(FUNC_DATA, 8'($urandom));
				end else if (pick < 90) begin
					send_command();
				end else if (pick < 94) begin
					// Hardware reset hold; sometimes left asserted for a later release
					send_link(FUNC_RST_ASSERT, 8'($urandom));
					n = $urandom_range(0, 3);
					for (k = 0; k < n; k++)
						send_link(2'($urandom_range(0, 1)), 8'($urandom));
					if ($urandom_range(0, 3) != 0) send_link(FUNC_RST_RELEASE, 8'($urandom));
				end else begin
					send_link(2'($urandom), 8'($urandom));
				end
			end
		end

		wait_idle();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

// ===== lcd_command_and_pixel_write_receiver.f =====
src/lcdrx_pkg.sv
src/lcdrx_in_reg.sv
src/lcdrx_core.sv
src/lcdrx_out.sv
src/lcd_command_and_pixel_write_receiver.sv
test/testbench.sv
